// ----- hw/rtl/hscl_pkg.sv -----
package hscl_pkg;

  localparam int NUM_PART    = 256;
  localparam int PART_BITS   = 8;
  localparam int LINK_BITS   = PART_BITS + 1;
  localparam int GRID_MAX    = 8;
  localparam int AXIS_BITS   = 3;
  localparam int GRID_BITS   = 4;
  localparam int CELL_BITS   = 3 * AXIS_BITS;
  localparam int NUM_CELLS   = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int COORD_BITS  = 24;
  localparam int RADIUS_BITS = 20;
  localparam int VALUE_BITS  = 25;
  localparam int SCALE_BITS  = 32;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 2;
  localparam int SUM_BITS    = COORD_BITS + 3;
  localparam int MAG_BITS    = COORD_BITS + 2;
  localparam int DIV_STEPS   = MAG_BITS;

  localparam logic [LINK_BITS-1:0] NO_LINK = LINK_BITS'(NUM_PART);

  localparam logic [OP_BITS-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_BITS-1:0] OP_MOVE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_SWAP = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_CLEAN   = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_OVERLAP = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_SKIP    = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_BAD     = 2'd3;

  localparam logic [CFG_ADDR_BITS-1:0] REG_BOX   = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CELLS = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SCALE = 2'd2;

  typedef struct packed {
    logic [COORD_BITS-1:0]  pos_x;
    logic [COORD_BITS-1:0]  pos_y;
    logic [COORD_BITS-1:0]  pos_z;
    logic [RADIUS_BITS-1:0] rad;
    logic [LINK_BITS-1:0]   nxt;
    logic [CELL_BITS-1:0]   home;
  } part_rec_t;

endpackage

// ----- hw/rtl/hard_sphere_cell_list_move_check.sv -----
// A load or move wraps the new position into the box by division, looks up its cell, then
// searches the 27 neighbour cells and each listed sphere in them, and unlinks any old list entry.
// A swap runs two such searches; early rejects, skips and equal radii end without a search.
// One item at a time: busy stays high until done; done pulses with status for one cycle.
// Synchronous reset: registers take their reset values, then a pass clears all 512
// cell heads while busy is high; the receiver cannot stall.
module hard_sphere_cell_list_move_check (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [hscl_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [hscl_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic start,
  output logic busy,
  input  logic [hscl_pkg::OP_BITS-1:0] op,
  input  logic [hscl_pkg::PART_BITS-1:0] particle,
  input  logic [hscl_pkg::PART_BITS-1:0] partner,
  input  logic signed [hscl_pkg::VALUE_BITS-1:0] value_x,
  input  logic signed [hscl_pkg::VALUE_BITS-1:0] value_y,
  input  logic signed [hscl_pkg::VALUE_BITS-1:0] value_z,
  input  logic [hscl_pkg::RADIUS_BITS-1:0] load_radius,
  output logic done,
  output logic [hscl_pkg::STATUS_BITS-1:0] status
);
  import hscl_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD_A, S_GOT_A, S_SW_CHK, S_SW_WB, S_DIV_PREP, S_DIV,
    S_DIV_FIX, S_AXIS, S_CELL, S_HEAD, S_ELEM, S_SQ, S_CMP, S_SDONE,
    S_UNL_START, S_UNL_HEAD, S_UNL_WALK, S_UNL_END, S_LINK_RD, S_LINK_W,
    S_RST_A, S_RST_B
  } state_t;

  state_t state;
  logic [CELL_BITS-1:0] clr_cnt;
  logic [COORD_BITS-1:0] box_length;
  logic [GRID_BITS-1:0] cells_per_side;
  logic [SCALE_BITS-1:0] cell_scale;
  logic [NUM_PART-1:0] stored;

  logic [OP_BITS-1:0] op_r;
  logic [PART_BITS-1:0] i_r, j_r, self_r, cur_j, p_r;
  logic signed [VALUE_BITS-1:0] val [3];
  logic [RADIUS_BITS-1:0] srch_r, rj;
  logic phase, ovl;
  part_rec_t rec_a, rec_b;
  logic signed [SUM_BITS-1:0] dv_val [3];
  logic dv_neg [3];
  logic [MAG_BITS-1:0] dv_mag [3];
  logic [COORD_BITS-1:0] rem [3];
  logic [4:0] div_cnt;
  logic [COORD_BITS-1:0] cand [3];
  logic [1:0] ax_cnt;
  logic [COORD_BITS+SCALE_BITS-1:0] prod;
  logic [AXIS_BITS-1:0] cc [3];
  logic [1:0] oa, ob, oc;
  logic [LINK_BITS-1:0] nxt;
  logic signed [VALUE_BITS-1:0] dd [3];
  logic [2*COORD_BITS-1:0] sq [3];
  logic [2*RADIUS_BITS+1:0] s2;

  part_rec_t pmem [NUM_PART];
  part_rec_t pmem_q;
  logic [LINK_BITS-1:0] cmem [NUM_CELLS];
  logic [LINK_BITS-1:0] cmem_q;

  logic [PART_BITS-1:0] pm_raddr, pm_waddr;
  logic pm_we;
  part_rec_t pm_wdata;
  logic [CELL_BITS-1:0] cm_raddr, cm_waddr;
  logic cm_we;
  logic [LINK_BITS-1:0] cm_wdata;

  logic [COORD_BITS-1:0] box_eff;
  logic [GRID_BITS-1:0] n_eff;
  logic [CELL_BITS-1:0] nb_cell, cen_cell;
  logic [AXIS_BITS-1:0] clamped;
  logic [COORD_BITS-1:0] ax_coord;
  logic last_cell;
  logic [COORD_BITS-1:0] rem_step [3];
  logic signed [VALUE_BITS-1:0] dd_next [3];
  logic signed [2*VALUE_BITS-1:0] sq_full [3];
  logic [RADIUS_BITS:0] rsum;
  logic [2*COORD_BITS+1:0] d2sum;

  function automatic logic [AXIS_BITS-1:0] nb_axis(input logic [AXIS_BITS-1:0] c,
                                                   input logic [1:0] o,
                                                   input logic [GRID_BITS-1:0] n);
    logic [GRID_BITS-1:0] t;
    logic [GRID_BITS-1:0] r;
    t = GRID_BITS'(c) + GRID_BITS'(o);
    if (t == '0) r = n - 4'd1;
    else if (t == n + 4'd1) r = '0;
    else r = t - 4'd1;
    return r[AXIS_BITS-1:0];
  endfunction

  function automatic logic [CELL_BITS-1:0] cell_of(input logic [AXIS_BITS-1:0] x,
                                                   input logic [AXIS_BITS-1:0] y,
                                                   input logic [AXIS_BITS-1:0] z,
                                                   input logic [GRID_BITS-1:0] n);
    logic [CELL_BITS:0] t;
    t = (((CELL_BITS+1)'(x) * (CELL_BITS+1)'(n)) + (CELL_BITS+1)'(y)) * (CELL_BITS+1)'(n)
        + (CELL_BITS+1)'(z);
    return t[CELL_BITS-1:0];
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] min_img(input logic [COORD_BITS-1:0] a,
                                                          input logic [COORD_BITS-1:0] b,
                                                          input logic [COORD_BITS-1:0] l);
    logic signed [COORD_BITS+1:0] d;
    logic signed [COORD_BITS+2:0] d2;
    logic signed [COORD_BITS+2:0] ls;
    d = $signed({2'b00, a}) - $signed({2'b00, b});
    d2 = {d, 1'b0};
    ls = $signed({3'b000, l});
    if (d2 > ls) d = d - $signed({2'b00, l});
    else if (d2 < -ls) d = d + $signed({2'b00, l});
    return d[VALUE_BITS-1:0];
  endfunction

  assign busy = (state != S_IDLE);
  assign box_eff = (box_length == '0) ? COORD_BITS'(1) : box_length;
  assign n_eff = (cells_per_side < 4'd3) ? 4'd3 :
                 (cells_per_side > GRID_BITS'(GRID_MAX)) ? GRID_BITS'(GRID_MAX) : cells_per_side;
  assign nb_cell = cell_of(nb_axis(cc[0], oa, n_eff), nb_axis(cc[1], ob, n_eff),
                           nb_axis(cc[2], oc, n_eff), n_eff);
  assign cen_cell = cell_of(cc[0], cc[1], cc[2], n_eff);
  assign last_cell = (oa == 2'd2) && (ob == 2'd2) && (oc == 2'd2);
  assign clamped = (prod[COORD_BITS+SCALE_BITS-1:COORD_BITS] >= SCALE_BITS'(n_eff)) ?
                   AXIS_BITS'(n_eff - 4'd1) : prod[COORD_BITS+AXIS_BITS-1:COORD_BITS];
  assign rsum = (RADIUS_BITS+1)'(srch_r) + (RADIUS_BITS+1)'(rj);
  assign d2sum = (2*COORD_BITS+2)'(sq[0]) + (2*COORD_BITS+2)'(sq[1])
               + (2*COORD_BITS+2)'(sq[2]);

  always_comb begin
    case (ax_cnt)
      2'd0:    ax_coord = cand[0];
      2'd1:    ax_coord = cand[1];
      default: ax_coord = cand[2];
    endcase
  end

  always_comb begin
    logic [COORD_BITS:0] t;
    for (int k = 0; k < 3; k++) begin
      t = {rem[k], dv_mag[k][MAG_BITS-1]};
      if (t >= {1'b0, box_eff}) t = t - {1'b0, box_eff};
      rem_step[k] = t[COORD_BITS-1:0];
    end
  end

  always_comb begin
    dd_next[0] = min_img(cand[0], pmem_q.pos_x, box_eff);
    dd_next[1] = min_img(cand[1], pmem_q.pos_y, box_eff);
    dd_next[2] = min_img(cand[2], pmem_q.pos_z, box_eff);
    for (int k = 0; k < 3; k++) sq_full[k] = dd[k] * dd[k];
  end

  always_comb begin
    pm_raddr = i_r;
    cm_raddr = rec_a.home;
    pm_we = 1'b0;
    pm_waddr = i_r;
    pm_wdata = rec_a;
    cm_we = 1'b0;
    cm_waddr = rec_a.home;
    cm_wdata = rec_a.nxt;
    unique case (state)
      S_CLEAR: begin
        cm_we = 1'b1;
        cm_waddr = clr_cnt;
        cm_wdata = NO_LINK;
      end
      S_GOT_A: begin
        pm_raddr = j_r;
        cm_raddr = pmem_q.home;
      end
      S_SW_CHK: begin
        pm_we = (pmem_q.rad != rec_a.rad);
        pm_wdata.rad = pmem_q.rad;
      end
      S_SW_WB: begin
        pm_we = 1'b1;
        pm_waddr = j_r;
        pm_wdata = rec_b;
        pm_wdata.rad = rec_a.rad;
      end
      S_CELL: cm_raddr = nb_cell;
      S_HEAD: pm_raddr = cmem_q[PART_BITS-1:0];
      S_ELEM: pm_raddr = pmem_q.nxt[PART_BITS-1:0];
      S_CMP: pm_raddr = nxt[PART_BITS-1:0];
      S_UNL_HEAD: begin
        pm_raddr = cmem_q[PART_BITS-1:0];
        cm_we = (cmem_q == {1'b0, i_r});
      end
      S_UNL_WALK: begin
        pm_raddr = pmem_q.nxt[PART_BITS-1:0];
        pm_we = (pmem_q.nxt == {1'b0, i_r});
        pm_waddr = p_r;
        pm_wdata = pmem_q;
        pm_wdata.nxt = rec_a.nxt;
      end
      S_LINK_RD: cm_raddr = cen_cell;
      S_LINK_W: begin
        cm_we = 1'b1;
        cm_waddr = cen_cell;
        cm_wdata = {1'b0, i_r};
        pm_we = 1'b1;
        pm_wdata = '{pos_x: cand[0], pos_y: cand[1], pos_z: cand[2], rad: srch_r,
                     nxt: cmem_q, home: cen_cell};
      end
      S_RST_A: pm_we = 1'b1;
      S_RST_B: begin
        pm_we = 1'b1;
        pm_waddr = j_r;
        pm_wdata = rec_b;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pm_we) pmem[pm_waddr] <= pm_wdata;
    pmem_q <= pmem[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (cm_we) cmem[cm_waddr] <= cm_wdata;
    cmem_q <= cmem[cm_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_length <= '1;
      cells_per_side <= 4'd3;
      cell_scale <= SCALE_BITS'(3);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BOX:   box_length <= cfg_data[COORD_BITS-1:0];
        REG_CELLS: cells_per_side <= cfg_data[GRID_BITS-1:0];
        REG_SCALE: cell_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      stored <= '0;
      done <= 1'b0;
      status <= ST_CLEAN;
      ax_cnt <= '0;
      div_cnt <= '0;
      oa <= '0;
      ob <= '0;
      oc <= '0;
      phase <= 1'b0;
      ovl <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op_r <= op;
            i_r <= particle;
            j_r <= partner;
            self_r <= particle;
            val[0] <= value_x;
            val[1] <= value_y;
            val[2] <= value_z;
            phase <= 1'b0;
            case (op)
              OP_LOAD: begin
                dv_val[0] <= SUM_BITS'(value_x);
                dv_val[1] <= SUM_BITS'(value_y);
                dv_val[2] <= SUM_BITS'(value_z);
                srch_r <= load_radius;
                state <= S_DIV_PREP;
              end
              OP_MOVE: begin
                if (stored[particle]) state <= S_RD_A;
                else begin
                  done <= 1'b1;
                  status <= ST_OVERLAP;
                end
              end
              OP_SWAP: begin
                if (!(stored[particle] && stored[partner])) begin
                  done <= 1'b1;
                  status <= ST_OVERLAP;
                end else if (particle == partner) begin
                  done <= 1'b1;
                  status <= ST_SKIP;
                end else state <= S_RD_A;
              end
              default: begin
                done <= 1'b1;
                status <= ST_SKIP;
              end
            endcase
          end
        end
        S_RD_A: state <= S_GOT_A;
        S_GOT_A: begin
          rec_a <= pmem_q;
          case (op_r)
            OP_LOAD: state <= S_UNL_HEAD;
            OP_MOVE: begin
              srch_r <= pmem_q.rad;
              dv_val[0] <= $signed({3'b000, pmem_q.pos_x}) + SUM_BITS'(val[0]);
              dv_val[1] <= $signed({3'b000, pmem_q.pos_y}) + SUM_BITS'(val[1]);
              dv_val[2] <= $signed({3'b000, pmem_q.pos_z}) + SUM_BITS'(val[2]);
              state <= S_DIV_PREP;
            end
            default: state <= S_SW_CHK;
          endcase
        end
        S_SW_CHK: begin
          rec_b <= pmem_q;
          if (pmem_q.rad == rec_a.rad) begin
            done <= 1'b1;
            status <= ST_SKIP;
            state <= S_IDLE;
          end else state <= S_SW_WB;
        end
        S_SW_WB: begin
          cand[0] <= rec_a.pos_x;
          cand[1] <= rec_a.pos_y;
          cand[2] <= rec_a.pos_z;
          srch_r <= rec_b.rad;
          self_r <= i_r;
          state <= S_AXIS;
        end
        S_DIV_PREP: begin
          for (int k = 0; k < 3; k++) begin
            dv_neg[k] <= dv_val[k][SUM_BITS-1];
            dv_mag[k] <= dv_val[k][SUM_BITS-1] ? MAG_BITS'(-dv_val[k])
                                               : MAG_BITS'(dv_val[k]);
            rem[k] <= '0;
          end
          div_cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          for (int k = 0; k < 3; k++) begin
            rem[k] <= rem_step[k];
            dv_mag[k] <= dv_mag[k] << 1;
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 5'(DIV_STEPS - 1)) state <= S_DIV_FIX;
        end
        S_DIV_FIX: begin
          for (int k = 0; k < 3; k++)
            cand[k] <= (dv_neg[k] && rem[k] != '0) ? box_eff - rem[k] : rem[k];
          if (op_r == OP_LOAD && stored[i_r]) state <= S_RD_A;
          else state <= S_AXIS;
        end
        S_AXIS: begin
          if (ax_cnt != 2'd0) cc[ax_cnt - 2'd1] <= clamped;
          if (ax_cnt != 2'd3) begin
            prod <= ax_coord * cell_scale;
            ax_cnt <= ax_cnt + 1'b1;
          end else begin
            ax_cnt <= '0;
            oa <= '0;
            ob <= '0;
            oc <= '0;
            state <= S_CELL;
          end
        end
        S_CELL: state <= S_HEAD;
        S_HEAD: begin
          if (cmem_q[PART_BITS]) begin
            if (last_cell) begin
              ovl <= 1'b0;
              state <= S_SDONE;
            end else begin
              if (oc != 2'd2) oc <= oc + 1'b1;
              else begin
                oc <= '0;
                if (ob != 2'd2) ob <= ob + 1'b1;
                else begin
                  ob <= '0;
                  oa <= oa + 1'b1;
                end
              end
              state <= S_CELL;
            end
          end else begin
            cur_j <= cmem_q[PART_BITS-1:0];
            state <= S_ELEM;
          end
        end
        S_ELEM: begin
          nxt <= pmem_q.nxt;
          rj <= pmem_q.rad;
          if (cur_j == self_r) begin
            if (pmem_q.nxt[PART_BITS]) begin
              if (last_cell) begin
                ovl <= 1'b0;
                state <= S_SDONE;
              end else begin
                if (oc != 2'd2) oc <= oc + 1'b1;
                else begin
                  oc <= '0;
                  if (ob != 2'd2) ob <= ob + 1'b1;
                  else begin
                    ob <= '0;
                    oa <= oa + 1'b1;
                  end
                end
                state <= S_CELL;
              end
            end else cur_j <= pmem_q.nxt[PART_BITS-1:0];
          end else begin
            for (int k = 0; k < 3; k++) dd[k] <= dd_next[k];
            state <= S_SQ;
          end
        end
        S_SQ: begin
          for (int k = 0; k < 3; k++) sq[k] <= sq_full[k][2*COORD_BITS-1:0];
          s2 <= rsum * rsum;
          state <= S_CMP;
        end
        S_CMP: begin
          if (d2sum < (2*COORD_BITS+2)'(s2)) begin
            ovl <= 1'b1;
            state <= S_SDONE;
          end else if (nxt[PART_BITS]) begin
            if (last_cell) begin
              ovl <= 1'b0;
              state <= S_SDONE;
            end else begin
              if (oc != 2'd2) oc <= oc + 1'b1;
              else begin
                oc <= '0;
                if (ob != 2'd2) ob <= ob + 1'b1;
                else begin
                  ob <= '0;
                  oa <= oa + 1'b1;
                end
              end
              state <= S_CELL;
            end
          end else begin
            cur_j <= nxt[PART_BITS-1:0];
            state <= S_ELEM;
          end
        end
        S_SDONE: begin
          case (op_r)
            OP_LOAD: state <= S_LINK_RD;
            OP_MOVE: begin
              if (ovl) begin
                done <= 1'b1;
                status <= ST_OVERLAP;
                state <= S_IDLE;
              end else state <= S_UNL_START;
            end
            default: begin
              if (ovl) state <= S_RST_A;
              else if (!phase) begin
                cand[0] <= rec_b.pos_x;
                cand[1] <= rec_b.pos_y;
                cand[2] <= rec_b.pos_z;
                srch_r <= rec_a.rad;
                self_r <= j_r;
                phase <= 1'b1;
                state <= S_AXIS;
              end else begin
                done <= 1'b1;
                status <= ST_CLEAN;
                state <= S_IDLE;
              end
            end
          endcase
        end
        S_UNL_START: state <= S_UNL_HEAD;
        S_UNL_HEAD: begin
          if (cmem_q == {1'b0, i_r} || cmem_q[PART_BITS]) state <= S_UNL_END;
          else begin
            p_r <= cmem_q[PART_BITS-1:0];
            state <= S_UNL_WALK;
          end
        end
        S_UNL_WALK: begin
          if (pmem_q.nxt == {1'b0, i_r} || pmem_q.nxt[PART_BITS]) state <= S_UNL_END;
          else p_r <= pmem_q.nxt[PART_BITS-1:0];
        end
        S_UNL_END: state <= (op_r == OP_LOAD) ? S_AXIS : S_LINK_RD;
        S_LINK_RD: state <= S_LINK_W;
        S_LINK_W: begin
          stored[i_r] <= 1'b1;
          done <= 1'b1;
          status <= (op_r == OP_LOAD && ovl) ? ST_OVERLAP : ST_CLEAN;
          state <= S_IDLE;
        end
        S_RST_A: state <= S_RST_B;
        S_RST_B: begin
          done <= 1'b1;
          status <= ST_OVERLAP;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/hscl_checker.sv -----
module hscl_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic [hscl_pkg::STATUS_BITS-1:0] status
);
  import hscl_pkg::*;

  a_reset_busy: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("block not busy after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result with no transfer in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status != ST_BAD)
    else $error("unused status code");

endmodule

bind hard_sphere_cell_list_move_check hscl_checker u_hscl_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .status(status)
);
